@@ rtl/icvt_pkg.sv @@
// Shared types and constants for the in-order commit visibility tracker.
`default_nettype none

package icvt_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int ID_W       = 64;
  localparam int OUT_CNT_W  = 7;
  localparam int STATUS_W   = 3;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPLICATE_ONLY = 2'd0,
    CFG_STORE_ENABLED  = 2'd1,
    CFG_RECOVERED_ID   = 2'd2
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_STOPPED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOT_LIVE = 3'd3,
    ST_DONE     = 3'd4,
    ST_BAD_LOG  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_APPLY,
    S_RETIRE,
    S_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic decide;
    logic apply;
    logic retire_step;
  } icvt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic retire_go;
    logic head_ready;
  } icvt_sts_t;

endpackage

`default_nettype wire

@@ rtl/inorder_commit_visibility_tracker_unit.sv @@
// Top level of the in-order commit visibility tracker.
// Usage: drive in_cmd, in_txn_id and in_log_id with start high; the beat is taken at
// a clock edge where start is high and busy is low. in_cmd selects allocate, finish or
// a status query. Each beat yields exactly one result beat, shown for one cycle with
// out_valid high; the receiver cannot stall it and must take it in that cycle.
// Sequence: the beat passes through the lookup, decide and apply states to the result
// state when nothing retires. A finish that frees the head then walks the finished head
// entries through the log id memory one entry per cycle in the retire state, and leaves
// it for the result state once the head entry is not finished or no id is live. A new
// beat may be accepted in the result cycle; while a beat is in flight busy stays high.
// Configuration: cfg_we writes register cfg_idx (0 replicate-only, 1 store enabled,
// 2 recovered last id) at once; write only while no beat is in flight. Writing the
// recovered id while no id is live reloads the id counters and the visible mark.
// Reset (synchronous, rst_n low): read-write mode, store enabled, no live ids,
// next and oldest id 1, visible mark 0. The log id memory needs no clearing pass.
`default_nettype none

module inorder_commit_visibility_tracker_unit import icvt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [ID_W-1:0]      in_txn_id,
  input  wire logic [ID_W-1:0]      in_log_id,
  output logic                      out_valid,
  output logic [STATUS_W-1:0]       out_status,
  output logic [ID_W-1:0]           out_new_id,
  output logic [ID_W-1:0]           out_highest_visible,
  output logic [OUT_CNT_W-1:0]      out_live_count,
  output logic [ID_W-1:0]           out_oldest_live,
  output logic [OUT_CNT_W-1:0]      out_retired_count,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ID_W-1:0]      cfg_wdata
);

  icvt_cmd_t cmd;
  icvt_sts_t sts;

  icvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  icvt_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_cmd              (in_cmd),
    .in_txn_id           (in_txn_id),
    .in_log_id           (in_log_id),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata),
    .out_status          (out_status),
    .out_new_id          (out_new_id),
    .out_highest_visible (out_highest_visible),
    .out_live_count      (out_live_count),
    .out_oldest_live     (out_oldest_live),
    .out_retired_count   (out_retired_count)
  );

endmodule

`default_nettype wire

@@ rtl/icvt_ctrl.sv @@
// Controller state machine that sequences lookup, decision, update and retirement.
`default_nettype none

module icvt_ctrl import icvt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire icvt_sts_t sts,
  output icvt_cmd_t      cmd,
  output logic           busy,
  output logic           out_valid
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE, S_RESULT: begin
        state_nxt = start ? S_LOOKUP : S_IDLE;
      end
      S_LOOKUP: state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_APPLY;
      S_APPLY: begin
        state_nxt = sts.retire_go ? S_RETIRE : S_RESULT;
      end
      S_RETIRE: begin
        state_nxt = sts.head_ready ? S_RETIRE : S_RESULT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_RESULT: begin
        busy        = 1'b0;
        out_valid   = 1'b1;
        cmd.capture = start;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_DECIDE: cmd.decide = 1'b1;
      S_APPLY:  cmd.apply  = 1'b1;
      S_RETIRE: cmd.retire_step = sts.head_ready;
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/icvt_dp.sv @@
// Datapath: id counters, finished flags, log id memory and result registers.
`default_nettype none

module icvt_dp import icvt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire icvt_cmd_t            cmd,
  output icvt_sts_t                 sts,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [ID_W-1:0]      in_txn_id,
  input  wire logic [ID_W-1:0]      in_log_id,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [ID_W-1:0]      cfg_wdata,
  output logic [STATUS_W-1:0]       out_status,
  output logic [ID_W-1:0]           out_new_id,
  output logic [ID_W-1:0]           out_highest_visible,
  output logic [OUT_CNT_W-1:0]      out_live_count,
  output logic [ID_W-1:0]           out_oldest_live,
  output logic [OUT_CNT_W-1:0]      out_retired_count
);

  localparam int SUM_W = CNT_W + 1;

  // Control state, initialized by reset.
  logic                  ro_r, ro_nxt;
  logic                  en_r, en_nxt;
  logic [ID_W-1:0]       vis_r, vis_nxt;
  logic [ID_W-1:0]       next_r, next_nxt;
  logic [ID_W-1:0]       oldest_r, oldest_nxt;
  logic [CNT_W-1:0]      live_r, live_nxt;
  logic [RING_AW-1:0]    head_r, head_nxt;
  logic [RING_DEPTH-1:0] flags_r, flags_nxt;

  // Per-item working registers.
  logic [CMD_W-1:0]      cmd_r;
  logic [ID_W-1:0]       txn_r;
  logic [ID_W-1:0]       log_r;
  logic [CNT_W-1:0]      off_r;
  logic                  in_range_r;
  logic                  bump_r;
  logic                  log_bad_r;
  logic [RING_AW-1:0]    slot_r;
  status_t               status_r;
  logic                  retire_go_r;
  logic [ID_W-1:0]       new_id_r;
  logic [ID_W-1:0]       head_log_r;
  logic [CNT_W-1:0]      retired_r;

  logic [ID_W-1:0]       log_mem [RING_DEPTH];
  logic [ID_W-1:0]       rd_data_r;

  logic [ID_W-1:0]       off_full;
  logic [SUM_W-1:0]      slot_sum;
  logic [RING_AW-1:0]    slot_c;
  logic [RING_AW-1:0]    head_inc;
  logic [RING_AW-1:0]    head_inc2;
  status_t               status_c;
  logic                  alloc_ok;
  logic                  finish_ok;

  assign off_full  = txn_r - oldest_r;
  assign head_inc  = (head_r == RING_AW'(RING_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign head_inc2 = (head_inc == RING_AW'(RING_DEPTH - 1)) ? '0 : head_inc + 1'b1;

  // The live offset is below the depth, so one conditional subtract wraps the slot.
  always_comb begin
    slot_sum = SUM_W'(head_r) + SUM_W'(off_r);
    if (slot_sum >= SUM_W'(RING_DEPTH)) begin
      slot_c = RING_AW'(slot_sum - SUM_W'(RING_DEPTH));
    end else begin
      slot_c = RING_AW'(slot_sum);
    end
  end

  always_comb begin
    status_c = en_r ? ST_OK : ST_STOPPED;
    case (cmd_r)
      CMD_ALLOC: begin
        if (!en_r) begin
          status_c = ST_STOPPED;
        end else if (bump_r && (live_r != '0)) begin
          status_c = ST_FULL;
        end else if (live_r == CNT_W'(RING_DEPTH)) begin
          status_c = ST_FULL;
        end else begin
          status_c = ST_OK;
        end
      end
      CMD_FINISH: begin
        if (!en_r) begin
          status_c = ST_STOPPED;
        end else if (!in_range_r) begin
          status_c = ST_NOT_LIVE;
        end else if (flags_r[slot_c]) begin
          status_c = ST_DONE;
        end else if (log_bad_r) begin
          status_c = ST_BAD_LOG;
        end else begin
          status_c = ST_OK;
        end
      end
      default: status_c = en_r ? ST_OK : ST_STOPPED;
    endcase
  end

  assign alloc_ok  = (status_r == ST_OK) && (cmd_r == CMD_ALLOC);
  assign finish_ok = (status_r == ST_OK) && (cmd_r == CMD_FINISH);

  always_comb begin
    ro_nxt     = ro_r;
    en_nxt     = en_r;
    vis_nxt    = vis_r;
    next_nxt   = next_r;
    oldest_nxt = oldest_r;
    live_nxt   = live_r;
    head_nxt   = head_r;
    flags_nxt  = flags_r;

    if (cfg_we) begin
      case (cfg_idx)
        CFG_REPLICATE_ONLY: ro_nxt = cfg_wdata[0];
        CFG_STORE_ENABLED:  en_nxt = cfg_wdata[0];
        CFG_RECOVERED_ID: begin
          if (live_r == '0) begin
            vis_nxt    = cfg_wdata;
            next_nxt   = cfg_wdata + 1'b1;
            oldest_nxt = cfg_wdata + 1'b1;
          end
        end
        default: begin
          ro_nxt = ro_r;
        end
      endcase
    end

    if (cmd.apply && alloc_ok) begin
      next_nxt = new_id_r + 1'b1;
      if (bump_r) begin
        oldest_nxt = new_id_r;
      end
      live_nxt = live_r + 1'b1;
    end

    if (cmd.apply && finish_ok) begin
      flags_nxt[slot_r] = 1'b1;
    end

    if (cmd.retire_step) begin
      if (head_log_r != '0) begin
        vis_nxt = head_log_r;
      end
      flags_nxt[head_r] = 1'b0;
      head_nxt          = head_inc;
      oldest_nxt        = oldest_r + 1'b1;
      live_nxt          = live_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ro_r     <= 1'b0;
      en_r     <= 1'b1;
      vis_r    <= '0;
      next_r   <= ID_W'(1);
      oldest_r <= ID_W'(1);
      live_r   <= '0;
      head_r   <= '0;
      flags_r  <= '0;
    end else begin
      ro_r     <= ro_nxt;
      en_r     <= en_nxt;
      vis_r    <= vis_nxt;
      next_r   <= next_nxt;
      oldest_r <= oldest_nxt;
      live_r   <= live_nxt;
      head_r   <= head_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      txn_r     <= in_txn_id;
      log_r     <= in_log_id;
      retired_r <= '0;
    end
    if (cmd.lookup) begin
      off_r      <= CNT_W'(off_full);
      in_range_r <= (off_full[ID_W-1:CNT_W] == '0) && (off_full[CNT_W-1:0] < live_r);
      bump_r     <= !ro_r && (next_r <= vis_r);
      log_bad_r  <= (log_r != '0) && (ro_r ? (log_r <= vis_r) : (log_r != txn_r));
    end
    if (cmd.decide) begin
      status_r    <= status_c;
      slot_r      <= slot_c;
      retire_go_r <= (cmd_r == CMD_FINISH) && (status_c == ST_OK) && (off_r == '0);
      if ((cmd_r == CMD_ALLOC) && (status_c == ST_OK)) begin
        new_id_r <= bump_r ? vis_r + 1'b1 : next_r;
      end else begin
        new_id_r <= '0;
      end
    end
    // The head entry's log id comes straight from the beat when it finishes the head;
    // after that each retirement takes the prefetched next entry.
    if (cmd.apply && finish_ok) begin
      head_log_r <= log_r;
    end else if (cmd.retire_step) begin
      head_log_r <= rd_data_r;
      retired_r  <= retired_r + 1'b1;
    end
  end

  // While the head moves, the read runs two entries ahead so each step finds its
  // log id ready.
  always_ff @(posedge clk) begin
    if (cmd.apply && finish_ok) begin
      log_mem[slot_r] <= log_r;
    end
    rd_data_r <= log_mem[cmd.retire_step ? head_inc2 : head_inc];
  end

  assign sts.retire_go  = retire_go_r;
  assign sts.head_ready = (live_r != '0) && flags_r[head_r];

  assign out_status          = status_r;
  assign out_new_id          = new_id_r;
  assign out_highest_visible = vis_r;
  assign out_live_count      = OUT_CNT_W'(live_r);
  assign out_oldest_live     = (live_r != '0) ? oldest_r : '0;
  assign out_retired_count   = OUT_CNT_W'(retired_r);

`ifndef SYNTHESIS
  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= CNT_W'(RING_DEPTH))
    else $error("live count exceeds ring depth");

  a_no_flags_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r == '0) |-> (flags_r == '0))
    else $error("finished flag set with no live id");

  a_retire_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.retire_step |=> (live_r == $past(live_r) - 1'b1))
    else $error("retirement did not remove the head entry");

  a_visible_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cmd.retire_step) && !$past(cfg_we)) |-> $stable(vis_r))
    else $error("visible mark moved without retirement or reload");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the in-order commit visibility tracker.
module tb;
  import icvt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    status_t            status;
    logic [ID_W-1:0]    new_id;
    logic [ID_W-1:0]    highest_visible;
    logic [OUT_CNT_W-1:0] live_count;
    logic [ID_W-1:0]    oldest_live;
    logic [OUT_CNT_W-1:0] retired_count;
  } beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [CMD_W-1:0]     in_cmd;
  logic [ID_W-1:0]      in_txn_id;
  logic [ID_W-1:0]      in_log_id;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_new_id;
  logic [ID_W-1:0]      out_highest_visible;
  logic [OUT_CNT_W-1:0] out_live_count;
  logic [ID_W-1:0]      out_oldest_live;
  logic [OUT_CNT_W-1:0] out_retired_count;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [ID_W-1:0]      cfg_wdata;

  inorder_commit_visibility_tracker_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_txn_id           (in_txn_id),
    .in_log_id           (in_log_id),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_new_id          (out_new_id),
    .out_highest_visible (out_highest_visible),
    .out_live_count      (out_live_count),
    .out_oldest_live     (out_oldest_live),
    .out_retired_count   (out_retired_count),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_wdata           (cfg_wdata)
  );

  // Tracker state as the testbench sees it.
  logic            mode_repl;
  logic            store_on;
  logic [ID_W-1:0] recovered_id;
  logic            done_flag [RING_DEPTH];
  logic [ID_W-1:0] slot_log [RING_DEPTH];
  logic [ID_W-1:0] head_id;
  int              live_n;
  logic [ID_W-1:0] next_grant;
  logic [ID_W-1:0] vis_mark;
  int              head_ptr;

  beat_t       pending_results[$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void reload_counters();
    next_grant = recovered_id + 64'd1;
    head_id    = next_grant;
    vis_mark   = recovered_id;
  endfunction

  function automatic void tracker_reset();
    mode_repl    = 1'b0;
    store_on     = 1'b1;
    recovered_id = '0;
    for (int i = 0; i < RING_DEPTH; i++) begin
      done_flag[i] = 1'b0;
      slot_log[i]  = '0;
    end
    live_n   = 0;
    head_ptr = 0;
    reload_counters();
  endfunction

  function automatic void tracker_config(cfg_reg_t idx, logic [ID_W-1:0] val);
    case (idx)
      CFG_REPLICATE_ONLY: mode_repl = val[0];
      CFG_STORE_ENABLED:  store_on = val[0];
      CFG_RECOVERED_ID: begin
        recovered_id = val;
        if (live_n == 0) reload_counters();
      end
      default: ;
    endcase
  endfunction

  // Applies one command to the tracker state and returns the beat it should answer.
  function automatic beat_t track_step(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] txn,
                                       logic [ID_W-1:0] lg);
    beat_t           r;
    logic [ID_W-1:0] off;
    int              slot;
    int              retired;
    r.status = ST_OK;
    r.new_id = '0;
    retired  = 0;
    case (cmd)
      CMD_ALLOC: begin
        if (!store_on) begin
          r.status = ST_STOPPED;
        end else if (!mode_repl && next_grant <= vis_mark && live_n != 0) begin
          r.status = ST_FULL;
        end else begin
          // In read-write mode an empty ring jumps its ids past the visible mark.
          if (!mode_repl && next_grant <= vis_mark) begin
            next_grant = vis_mark + 64'd1;
            head_id    = next_grant;
          end
          if (live_n >= RING_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot            = (head_ptr + live_n) % RING_DEPTH;
            done_flag[slot] = 1'b0;
            slot_log[slot]  = '0;
            r.new_id        = next_grant;
            next_grant      = next_grant + 64'd1;
            live_n++;
          end
        end
      end
      CMD_FINISH: begin
        off = txn - head_id;
        if (!store_on) begin
          r.status = ST_STOPPED;
        end else if (off >= 64'(live_n)) begin
          r.status = ST_NOT_LIVE;
        end else begin
          slot = (head_ptr + int'(off[6:0])) % RING_DEPTH;
          if (done_flag[slot]) begin
            r.status = ST_DONE;
          end else if (lg != '0 && (mode_repl ? (lg <= vis_mark) : (lg != txn))) begin
            r.status = ST_BAD_LOG;
          end else begin
            done_flag[slot] = 1'b1;
            slot_log[slot]  = lg;
            if (off == '0) begin
              while (live_n != 0 && done_flag[head_ptr]) begin
                if (slot_log[head_ptr] != '0) vis_mark = slot_log[head_ptr];
                done_flag[head_ptr] = 1'b0;
                head_ptr = (head_ptr + 1) % RING_DEPTH;
                head_id  = head_id + 64'd1;
                live_n--;
                retired++;
              end
            end
          end
        end
      end
      default: r.status = store_on ? ST_OK : ST_STOPPED;
    endcase
    r.highest_visible = vis_mark;
    r.live_count      = OUT_CNT_W'(live_n);
    r.oldest_live     = (live_n != 0) ? head_id : '0;
    r.retired_count   = OUT_CNT_W'(retired);
    return r;
  endfunction

  function automatic void check_field(string name, logic [ID_W-1:0] want,
                                      logic [ID_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    beat_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("new_id", want.new_id, out_new_id);
        check_field("highest_visible", want.highest_visible, out_highest_visible);
        check_field("live_count", 64'(want.live_count), 64'(out_live_count));
        check_field("oldest_live", want.oldest_live, out_oldest_live);
        check_field("retired_count", 64'(want.retired_count), 64'(out_retired_count));
      end
    end
  end

  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] txn,
                           logic [ID_W-1:0] lg);
    @(negedge clk);
    start     = 1'b1;
    in_cmd    = cmd;
    in_txn_id = txn;
    in_log_id = lg;
    do @(posedge clk); while (busy);
    pending_results.push_back(track_step(cmd, txn, lg));
  endtask

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic pause_inputs();
    int n;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Lets every outstanding command answer before the registers are touched.
  task automatic wait_idle();
    @(negedge clk) start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [ID_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(posedge clk);
    tracker_config(idx, val);
    @(negedge clk) cfg_we = 1'b0;
  endtask

  function automatic logic [ID_W-1:0] pick_log(logic [ID_W-1:0] txn);
    int r;
    r = $urandom_range(99);
    if (r < 30) return '0;
    if (r < 36) return {$urandom, $urandom};
    if (!mode_repl) return txn;
    return vis_mark + 64'($urandom_range(1, 1000));
  endfunction

  task automatic issue_random_beat(int alloc_pct);
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  txn;
    logic [ID_W-1:0]  lg;
    int               open_ids[$];
    int               r;
    r   = $urandom_range(99);
    cmd = CMD_W'($urandom_range(3));
    txn = {$urandom, $urandom};
    lg  = {$urandom, $urandom};
    if (r >= 10) begin
      for (int o = 0; o < live_n; o++)
        if (!done_flag[(head_ptr + o) % RING_DEPTH]) open_ids.push_back(o);
      if (open_ids.size() == 0 || $urandom_range(99) < alloc_pct) begin
        cmd = CMD_ALLOC;
      end else begin
        cmd = CMD_FINISH;
        txn = head_id + 64'(open_ids[$urandom_range(open_ids.size() - 1)]);
        lg  = pick_log(txn);
      end
    end else if (r >= 4 && live_n != 0) begin
      // Near misses: ids that may already be finished, or one past the live run.
      cmd = CMD_FINISH;
      txn = head_id + 64'($urandom_range(live_n));
      if ($urandom_range(1) == 1) lg = pick_log(txn);
    end
    send_beat(cmd, txn, lg);
  endtask

  // Finishes every open entry, youngest first, so the head retires the whole run.
  task automatic retire_all();
    logic [ID_W-1:0] ids[$];
    logic [ID_W-1:0] txn;
    for (int o = live_n - 1; o >= 0; o--)
      if (!done_flag[(head_ptr + o) % RING_DEPTH]) ids.push_back(head_id + 64'(o));
    foreach (ids[i]) begin
      txn = ids[i];
      send_beat(CMD_FINISH, txn, mode_repl ? '0 : txn);
      pause_inputs();
    end
  endtask

  task automatic run_phase(bit repl, bit en, logic [ID_W-1:0] rec, bit flush,
                           int count, int alloc_pct);
    wait_idle();
    write_reg(CFG_REPLICATE_ONLY, 64'(repl));
    write_reg(CFG_STORE_ENABLED, 64'(en));
    if (flush) begin
      retire_all();
      wait_idle();
    end
    write_reg(CFG_RECOVERED_ID, rec);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(49) == 0) no_idle = !no_idle;
      issue_random_beat(alloc_pct);
      pause_inputs();
    end
  endtask

  task automatic test_query_codes();
    send_beat(CMD_QUERY, '0, '0);
    send_beat(CMD_UNUSED, '1, '1);
    send_beat(CMD_FINISH, '0, '0);
    send_beat(CMD_FINISH, '1, '1);
  endtask

  task automatic test_commit_ordering();
    logic [ID_W-1:0] base;
    base = next_grant;
    repeat (4) send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_FINISH, base + 2, base + 2);
    send_beat(CMD_FINISH, base + 2, base + 2);
    send_beat(CMD_FINISH, base + 1, base + 7);
    send_beat(CMD_FINISH, base + 1, '0);
    send_beat(CMD_FINISH, base, base);
    send_beat(CMD_FINISH, base + 3, base + 3);
    send_beat(CMD_FINISH, base + 3, base + 3);
  endtask

  task automatic test_stopped_store();
    wait_idle();
    write_reg(CFG_STORE_ENABLED, 64'd0);
    send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_FINISH, next_grant, '0);
    send_beat(CMD_QUERY, '0, '0);
    wait_idle();
    write_reg(CFG_STORE_ENABLED, 64'd1);
  endtask

  task automatic test_replicate_and_bump();
    logic [ID_W-1:0] base;
    wait_idle();
    write_reg(CFG_REPLICATE_ONLY, 64'd1);
    base = next_grant;
    send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_FINISH, base + 1, vis_mark);
    send_beat(CMD_FINISH, base + 1, '1);
    send_beat(CMD_FINISH, base, '0);
    // The mark is now at the top, so read-write allocation must jump and wrap.
    wait_idle();
    write_reg(CFG_REPLICATE_ONLY, 64'd0);
    send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_ALLOC, '0, '0);
    send_beat(CMD_FINISH, head_id, '0);
    wait_idle();
    write_reg(CFG_RECOVERED_ID, 64'd0);
  endtask

  task automatic test_readwrite_traffic();
    run_phase(1'b0, 1'b1, 64'd0, 1'b0, 240, 55);
  endtask

  task automatic test_replicate_traffic();
    run_phase(1'b1, 1'b1, {$urandom, $urandom}, 1'b0, 200, 50);
  endtask

  task automatic test_id_wrap_traffic();
    run_phase(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFD0, 1'b1, 200, 65);
  endtask

  task automatic test_stopped_traffic();
    run_phase(1'b0, 1'b0, '1, 1'b0, 40, 50);
  endtask

  task automatic test_saturated_mark();
    run_phase(1'b1, 1'b1, '1, 1'b1, 80, 50);
  endtask

  task automatic test_mixed_traffic();
    run_phase(1'b0, 1'b1, {$urandom, $urandom}, 1'b1, 240, 65);
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    @(negedge clk) start = 1'b0;
    while (pending_results.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      fail_count++;
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_cmd    = CMD_QUERY;
    in_txn_id = '0;
    in_log_id = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_REPLICATE_ONLY;
    cfg_wdata = '0;
    tracker_reset();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_query_codes();
    test_commit_ordering();
    test_stopped_store();
    test_replicate_and_bump();
    test_readwrite_traffic();
    test_replicate_traffic();
    test_id_wrap_traffic();
    test_stopped_traffic();
    test_saturated_mark();
    test_mixed_traffic();
    finish_run();
  end

endmodule

@@ filelist.f @@
rtl/icvt_pkg.sv
rtl/icvt_ctrl.sv
rtl/icvt_dp.sv
rtl/inorder_commit_visibility_tracker_unit.sv
tb/sv/tb.sv
